// ===== src/sld_pkg.sv =====
package sld_pkg;

    localparam logic [7:0]  SYNC_FIRST     = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND    = 8'h5A;
    localparam logic [7:0]  CMD_ONLINE     = 8'h03;
    localparam logic [7:0]  CMD_FINAL      = 8'h04;
    localparam logic [7:0]  CMD_MORE       = 8'h14;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd512;
    localparam int          OUT_DEPTH      = 2;
    localparam int          OUT_PTR_W      = $clog2(OUT_DEPTH);
    localparam int          OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LENL  = 3'd2,
        PH_LENH  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_GOOD       = 2'd1,
        EV_BAD_SUM    = 2'd2,
        EV_LEN_REJECT = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        KIND_OTHER       = 2'd0,
        KIND_ONLINE      = 2'd1,
        KIND_RECORD_LAST = 2'd2,
        KIND_RECORD_MORE = 2'd3
    } t_kind;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        t_event      frame_event;
        t_kind       message_kind;
        logic [15:0] frame_length;
    } t_result;

    function automatic t_kind kind_of(input logic [7:0] cmd);
        t_kind k;
        case (cmd)
            CMD_ONLINE: k = KIND_ONLINE;
            CMD_FINAL:  k = KIND_RECORD_LAST;
            CMD_MORE:   k = KIND_RECORD_MORE;
            default:    k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

// ===== src/sld_parser.sv =====
module sld_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_space,
    output logic              o_res_valid,
    output sld_pkg::t_result  o_res
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [15:0]      r_max_length;
    sld_pkg::t_phase  r_phase;
    logic [15:0]      r_payload_length;
    logic [15:0]      r_bytes_received;
    logic [7:0]       r_running_sum;
    logic [7:0]       r_command_byte;

    sld_pkg::t_phase  n_phase;
    logic [15:0]      n_payload_length;
    logic [15:0]      n_bytes_received;
    logic [7:0]       n_running_sum;
    logic [7:0]       n_command_byte;
    logic [15:0]      len_next;
    logic [15:0]      count_next;
    logic             accept;
    logic             advance;
    sld_pkg::t_result res;

    assign advance     = r_in_valid && i_space;
    assign o_in_stall  = r_in_valid && !i_space;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_res_valid = advance;
    assign o_res       = res;
    assign len_next    = {r_in_byte, r_payload_length[7:0]};
    assign count_next  = r_bytes_received + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !advance);
        end
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= sld_pkg::MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_length <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= sld_pkg::PH_HUNT1;
            r_payload_length <= '0;
            r_bytes_received <= '0;
            r_running_sum    <= '0;
            r_command_byte   <= '0;
        end else if (advance) begin
            r_phase          <= n_phase;
            r_payload_length <= n_payload_length;
            r_bytes_received <= n_bytes_received;
            r_running_sum    <= n_running_sum;
            r_command_byte   <= n_command_byte;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_payload_length = r_payload_length;
        n_bytes_received = r_bytes_received;
        n_running_sum    = r_running_sum;
        n_command_byte   = r_command_byte;
        res              = '0;
        case (r_phase)
            sld_pkg::PH_HUNT1: begin
                if (r_in_byte == sld_pkg::SYNC_FIRST) begin
                    n_phase = sld_pkg::PH_HUNT2;
                end
            end
            sld_pkg::PH_HUNT2: begin
                if (r_in_byte == sld_pkg::SYNC_SECOND) begin
                    n_phase          = sld_pkg::PH_LENL;
                    n_payload_length = '0;
                end else begin
                    n_phase = sld_pkg::PH_HUNT1;
                end
            end
            sld_pkg::PH_LENL: begin
                n_payload_length = {r_payload_length[15:8], r_in_byte};
                n_phase          = sld_pkg::PH_LENH;
            end
            sld_pkg::PH_LENH: begin
                n_payload_length = len_next;
                if (len_next > r_max_length) begin
                    res.frame_event  = sld_pkg::EV_LEN_REJECT;
                    res.frame_length = len_next;
                    n_phase          = sld_pkg::PH_HUNT1;
                end else begin
                    n_bytes_received = '0;
                    n_running_sum    = '0;
                    n_command_byte   = '0;
                    n_phase = (len_next == 16'd0) ? sld_pkg::PH_CSUM : sld_pkg::PH_DATA;
                end
            end
            sld_pkg::PH_DATA: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = r_in_byte;
                res.payload_index = r_bytes_received;
                if (r_bytes_received == 16'd0) begin
                    n_command_byte = r_in_byte;
                end
                n_running_sum    = r_running_sum + r_in_byte;
                n_bytes_received = count_next;
                if (count_next >= r_payload_length) begin
                    n_phase = sld_pkg::PH_CSUM;
                end
            end
            sld_pkg::PH_CSUM: begin
                res.frame_length = r_payload_length;
                if (r_running_sum == r_in_byte) begin
                    res.frame_event  = sld_pkg::EV_GOOD;
                    res.message_kind = sld_pkg::kind_of(r_command_byte);
                end else begin
                    res.frame_event = sld_pkg::EV_BAD_SUM;
                end
                n_phase = sld_pkg::PH_HUNT1;
            end
            default: begin
                n_phase = sld_pkg::PH_HUNT1;
            end
        endcase
    end

endmodule

// ===== src/sld_out_fifo.sv =====
module sld_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sld_pkg::t_result  i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_stall,
    output sld_pkg::t_result  o_data
);

    sld_pkg::t_result                r_mem [sld_pkg::OUT_DEPTH];
    logic [sld_pkg::OUT_PTR_W-1:0]   r_wr_ptr;
    logic [sld_pkg::OUT_PTR_W-1:0]   r_rd_ptr;
    logic [sld_pkg::OUT_CNT_W-1:0]   r_count;
    logic                            pop;

    assign o_valid = (r_count != '0);
    assign o_space = (r_count != sld_pkg::OUT_CNT_W'(sld_pkg::OUT_DEPTH));
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == sld_pkg::OUT_PTR_W'(sld_pkg::OUT_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == sld_pkg::OUT_PTR_W'(sld_pkg::OUT_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/sync_length_checksum_deframer.sv =====
// Byte-stream deframer: hunts for the sync pair A5 5A, takes a 16-bit
// little-endian length, passes each payload byte out with its index, then
// checks the 8-bit additive checksum byte and reports good, mismatch or
// length rejected, with the kind of message taken from the first payload
// byte. Every accepted byte yields exactly one result beat. One byte is taken
// per clock cycle while results drain; the parser state, running sum and byte
// counter update together as each byte advances. An accepted byte waits in the
// input register until the output queue has space, then its result beat is
// written into that two-entry queue and offered from there; the input stalls
// only while the queue is full and the input register holds a byte. max_length
// may be written only while no beat is in flight.
module sync_length_checksum_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_index,
    output logic [1:0]  o_frame_event,
    output logic [1:0]  o_message_kind,
    output logic [15:0] o_frame_length
);

    logic             space;
    logic             res_valid;
    sld_pkg::t_result res;
    sld_pkg::t_result out_res;

    sld_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_space       (space),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    sld_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_payload_valid = out_res.payload_valid;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_frame_event   = out_res.frame_event;
    assign o_message_kind  = out_res.message_kind;
    assign o_frame_length  = out_res.frame_length;

endmodule

// ===== src/sld_checker.sv =====
module sld_props (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_payload_valid,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_payload_index,
    input  logic [1:0]  i_frame_event,
    input  logic [1:0]  i_message_kind,
    input  logic [15:0] i_frame_length
);

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_payload_valid)
        && $stable(i_payload_byte) && $stable(i_payload_index)
        && $stable(i_frame_event) && $stable(i_message_kind) && $stable(i_frame_length))
        else $error("stalled result beat changed");

    a_payload_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_payload_valid |-> i_frame_event == sld_pkg::EV_NONE)
        else $error("payload beat carries a frame event");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_payload_valid |-> i_payload_byte == 8'd0
        && i_payload_index == 16'd0)
        else $error("non-payload beat has payload fields");

    a_kind_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_event != sld_pkg::EV_GOOD |->
        i_message_kind == sld_pkg::KIND_OTHER)
        else $error("message kind set without a good frame");

    a_length_only_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_event == sld_pkg::EV_NONE |-> i_frame_length == 16'd0)
        else $error("frame length set without an event");

endmodule

bind sync_length_checksum_deframer sld_props u_sld_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .i_payload_valid (o_payload_valid),
    .i_payload_byte  (o_payload_byte),
    .i_payload_index (o_payload_index),
    .i_frame_event   (o_frame_event),
    .i_message_kind  (o_message_kind),
    .i_frame_length  (o_frame_length)
);
